>>> rtl/triangle_scanline_span_assert.svh
// Assertion macros shared by the checker of the span generator.
`ifndef TRIANGLE_SCANLINE_SPAN_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, when seen, must be followed by another on the next edge.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tss_pkg.sv
// Package of shared types and constants for the triangle span generator.
package tss_pkg;

  // Width of every coordinate field.
  localparam int COORD_BITS = 12;
  // Width of the magnitude of an edge product, which is also the divider word.
  localparam int NUM_BITS = 2 * COORD_BITS;
  // Number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] row;
    logic [7:0]                   colour_red;
    logic [7:0]                   colour_green;
    logic [7:0]                   colour_blue;
  } tss_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] span_start_x;
    logic signed [COORD_BITS-1:0] span_end_x;
    logic                         upper_half;
    logic [7:0]                   red_out;
    logic [7:0]                   green_out;
    logic [7:0]                   blue_out;
    logic                         last_span;
  } tss_out_t;

  // One classified row query: which halves give a span, the edge products
  // (sign and magnitude) and the divisors for the lower, upper and long edges.
  typedef struct packed {
    logic                         lo_en;
    logic                         up_en;
    logic                         neg_lo;
    logic                         neg_up;
    logic                         neg_long;
    logic [NUM_BITS-1:0]          w_lo;
    logic [NUM_BITS-1:0]          w_up;
    logic [NUM_BITS-1:0]          w_long;
    logic [COORD_BITS-1:0]        den_lo;
    logic [COORD_BITS-1:0]        den_up;
    logic [COORD_BITS-1:0]        den_long;
    logic signed [COORD_BITS-1:0] bot_x;
    logic signed [COORD_BITS-1:0] mid_x;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
  } tss_job_t;

endpackage

>>> rtl/tss_front.sv
// Front end: accepts row queries, sorts the vertices, classifies and forms edge products.
module tss_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tss_pkg::tss_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output tss_pkg::tss_job_t job
);

  localparam int CB = tss_pkg::COORD_BITS;
  localparam int NW = tss_pkg::NUM_BITS;

  typedef struct packed {
    logic                 lo_en;
    logic                 up_en;
    logic signed [CB:0]   dx_lo;
    logic signed [CB:0]   dx_up;
    logic signed [CB:0]   dx_long;
    logic signed [CB:0]   dr_lo;
    logic signed [CB:0]   dr_up;
    logic [CB-1:0]        den_lo;
    logic [CB-1:0]        den_up;
    logic [CB-1:0]        den_long;
    logic signed [CB-1:0] bot_x;
    logic signed [CB-1:0] mid_x;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } sort_t;

  // Difference of two coordinates, one bit wider so it cannot overflow.
  function automatic logic signed [CB:0] diff(input logic signed [CB-1:0] a,
                                              input logic signed [CB-1:0] b);
    diff = {a[CB-1], a} - {b[CB-1], b};
  endfunction

  logic signed [CB-1:0] t1_x, t1_y, m1_x, m1_y;
  logic signed [CB-1:0] t2_x, t2_y, b2_x, b2_y;
  logic signed [CB-1:0] m3_x, m3_y, b3_x, b3_y;
  logic                 degen, keep;
  logic signed [CB:0]   den_lo_w, den_up_w, den_long_w;
  sort_t                sort_next;
  sort_t                srt;
  logic                 srt_valid;
  logic                 srt_ready;
  logic signed [2*CB+1:0] p_lo, p_up, p_long;
  logic signed [2*CB+1:0] a_lo, a_up, a_long;
  tss_pkg::tss_job_t    job_next;

  // Three compare-and-swap steps order the vertices top, middle, bottom.
  always_comb begin
    if (in_data.vertex_a_y < in_data.vertex_b_y) begin
      t1_x = in_data.vertex_b_x; t1_y = in_data.vertex_b_y;
      m1_x = in_data.vertex_a_x; m1_y = in_data.vertex_a_y;
    end else begin
      t1_x = in_data.vertex_a_x; t1_y = in_data.vertex_a_y;
      m1_x = in_data.vertex_b_x; m1_y = in_data.vertex_b_y;
    end
    if (t1_y < in_data.vertex_c_y) begin
      t2_x = in_data.vertex_c_x; t2_y = in_data.vertex_c_y;
      b2_x = t1_x;               b2_y = t1_y;
    end else begin
      t2_x = t1_x;               t2_y = t1_y;
      b2_x = in_data.vertex_c_x; b2_y = in_data.vertex_c_y;
    end
    if (m1_y < b2_y) begin
      m3_x = b2_x; m3_y = b2_y;
      b3_x = m1_x; b3_y = m1_y;
    end else begin
      m3_x = m1_x; m3_y = m1_y;
      b3_x = b2_x; b3_y = b2_y;
    end
  end

  // Classification: which halves hold the row, and the edge deltas.
  always_comb begin
    degen = (in_data.vertex_a_y == in_data.vertex_b_y &&
             in_data.vertex_b_y == in_data.vertex_c_y) ||
            (in_data.vertex_a_x == in_data.vertex_b_x &&
             in_data.vertex_b_x == in_data.vertex_c_x);
    den_lo_w   = diff(m3_y, b3_y);
    den_up_w   = diff(t2_y, m3_y);
    den_long_w = diff(t2_y, b3_y);
    sort_next.lo_en    = (m3_y > b3_y) && (in_data.row >= b3_y) && (in_data.row <= m3_y);
    sort_next.up_en    = (t2_y > m3_y) && (in_data.row >= m3_y) && (in_data.row <= t2_y);
    sort_next.dx_lo    = diff(m3_x, b3_x);
    sort_next.dx_up    = diff(t2_x, m3_x);
    sort_next.dx_long  = diff(t2_x, b3_x);
    sort_next.dr_lo    = diff(in_data.row, b3_y);
    sort_next.dr_up    = diff(in_data.row, m3_y);
    sort_next.den_lo   = den_lo_w[CB-1:0];
    sort_next.den_up   = den_up_w[CB-1:0];
    sort_next.den_long = den_long_w[CB-1:0];
    sort_next.bot_x    = b3_x;
    sort_next.mid_x    = m3_x;
    sort_next.red      = in_data.colour_red;
    sort_next.green    = in_data.colour_green;
    sort_next.blue     = in_data.colour_blue;
    keep = !degen && (sort_next.lo_en || sort_next.up_en);
  end

  // Handshake: each stage moves when the one after it has room.
  assign srt_ready = !job_valid || job_ready;
  assign in_ready  = !srt_valid || srt_ready;

  // Sort stage register; queries that give no span are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      srt_valid <= 1'b0;
    end else if (in_ready) begin
      srt_valid <= in_valid && keep;
    end
    if (in_ready) begin
      srt <= sort_next;
    end
  end

  // Edge products, split into sign and magnitude for the divider.
  always_comb begin
    p_lo   = srt.dx_lo * srt.dr_lo;
    p_up   = srt.dx_up * srt.dr_up;
    p_long = srt.dx_long * srt.dr_lo;
    a_lo   = p_lo[2*CB+1] ? -p_lo : p_lo;
    a_up   = p_up[2*CB+1] ? -p_up : p_up;
    a_long = p_long[2*CB+1] ? -p_long : p_long;
    job_next.lo_en    = srt.lo_en;
    job_next.up_en    = srt.up_en;
    job_next.neg_lo   = p_lo[2*CB+1];
    job_next.neg_up   = p_up[2*CB+1];
    job_next.neg_long = p_long[2*CB+1];
    job_next.w_lo     = a_lo[NW-1:0];
    job_next.w_up     = a_up[NW-1:0];
    job_next.w_long   = a_long[NW-1:0];
    job_next.den_lo   = srt.den_lo;
    job_next.den_up   = srt.den_up;
    job_next.den_long = srt.den_long;
    job_next.bot_x    = srt.bot_x;
    job_next.mid_x    = srt.mid_x;
    job_next.red      = srt.red;
    job_next.green    = srt.green;
    job_next.blue     = srt.blue;
  end

  // Product stage register feeding the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (srt_ready) begin
      job_valid <= srt_valid;
    end
    if (srt_ready) begin
      job <= job_next;
    end
  end

endmodule

>>> rtl/tss_queue.sv
// Short queue of classified jobs between the front and back ends.
module tss_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  tss_pkg::tss_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tss_pkg::tss_job_t pop_job
);

  localparam int DEPTH = tss_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  tss_pkg::tss_job_t entry [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;
  logic              push, pop;

  assign push_ready = (count != DEPTH[AW:0]);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entry[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

>>> rtl/tss_back.sv
// Back end: pipelined edge dividers and the span output register.
module tss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  tss_pkg::tss_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output tss_pkg::tss_out_t out_data
);

  localparam int CB = tss_pkg::COORD_BITS;
  localparam int NW = tss_pkg::NUM_BITS;

  // One restoring division step: shifts in a dividend bit, shifts a quotient bit in at the low end.
  function automatic logic [NW-1:0] div_step(input logic [NW-1:0] w,
                                             input logic [CB-1:0] d);
    logic [CB:0] t;
    logic [CB:0] s;
    logic        q;
    t = w[NW-1:CB-1];
    q = (t >= {1'b0, d});
    s = q ? (t - {1'b0, d}) : t;
    div_step = {s[CB-1:0], w[CB-2:0], q};
  endfunction

  // Edge x from its base, the sign of the product and the quotient magnitude.
  function automatic logic signed [CB-1:0] edge_x(input logic signed [CB-1:0] base,
                                                  input logic neg,
                                                  input logic [CB-1:0] q);
    logic signed [CB:0] e;
    logic signed [CB:0] sum;
    e   = {base[CB-1], base};
    sum = neg ? (e - {1'b0, q}) : (e + {1'b0, q});
    edge_x = sum[CB-1:0];
  endfunction

  tss_pkg::tss_job_t pipe [CB+1];
  tss_pkg::tss_job_t pipe_next [CB+1];
  logic [CB:0]       pv;
  logic              adv, load, two, finish, lo_done;
  tss_pkg::tss_job_t hd;
  tss_pkg::tss_out_t span_next;

  assign hd     = pipe[CB];
  assign two    = hd.lo_en && hd.up_en;
  assign load   = pv[CB] && (!out_valid || out_ready);
  assign finish = load && (!two || lo_done);
  assign adv    = !pv[CB] || finish;
  assign job_ready = adv;

  // Next contents of each divider stage: a quotient bit for each of the lower, upper and long edges.
  always_comb begin
    pipe_next[0] = job;
    for (int k = 1; k <= CB; k++) begin
      pipe_next[k]        = pipe[k-1];
      pipe_next[k].w_lo   = div_step(pipe[k-1].w_lo,   pipe[k-1].den_lo);
      pipe_next[k].w_up   = div_step(pipe[k-1].w_up,   pipe[k-1].den_up);
      pipe_next[k].w_long = div_step(pipe[k-1].w_long, pipe[k-1].den_long);
    end
  end

  // Divider pipeline: a quotient bit per stage, the lower, upper and long edges side by side.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[CB-1:0], job_valid};
    end
    if (adv) begin
      for (int k = 0; k <= CB; k++) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // Span selection: the lower span goes first when a row gives both.
  always_comb begin
    span_next.span_end_x = edge_x(hd.bot_x, hd.neg_long, hd.w_long[CB-1:0]);
    if (hd.lo_en && !lo_done) begin
      span_next.span_start_x = edge_x(hd.bot_x, hd.neg_lo, hd.w_lo[CB-1:0]);
      span_next.upper_half   = 1'b0;
    end else begin
      span_next.span_start_x = edge_x(hd.mid_x, hd.neg_up, hd.w_up[CB-1:0]);
      span_next.upper_half   = 1'b1;
    end
    span_next.red_out   = hd.red;
    span_next.green_out = hd.green;
    span_next.blue_out  = hd.blue;
    span_next.last_span = !two || lo_done;
  end

  // Output register and the flag that remembers a lower span already sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lo_done   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        lo_done   <= two && !lo_done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_data <= span_next;
    end
  end

endmodule

>>> rtl/triangle_scanline_span.sv
// Top level of the triangle scanline span generator.
// Takes one row query (three vertices, a row and a colour) per clock cycle when
// not stalled by in_ready, and gives zero, one or two spans for it. A query on
// the middle row that yields both spans sends them one after the other through
// the single output register and stalls the dividers meanwhile. The divider
// pipeline resolves a quotient bit per stage for the lower, upper and long edges.
// Queries that give no span are dropped in the front end; a four-entry queue
// separates the front end from the dividers.
module triangle_scanline_span (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tss_pkg::tss_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tss_pkg::tss_out_t out_data
);

  logic              f_valid, f_ready, q_valid, q_ready;
  tss_pkg::tss_job_t f_job, q_job;

  tss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  tss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  tss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/tss_checker.sv
// Port checker for the span generator and its bind to the top level.
`include "triangle_scanline_span_assert.svh"

module tss_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input tss_pkg::tss_out_t out_data
);

  // A stalled span stays offered unchanged.
  `TSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "span changed while stalled")
  // A span that is not the last of its query is always the lower one.
  `TSS_ASSERT(a_first_lower, !(out_valid && !out_data.last_span) || !out_data.upper_half, "non-final span is not lower")
  // The upper span follows a lower one straight away.
  `TSS_ASSERT_NEXT(a_pair_next, out_valid && out_ready && !out_data.last_span, out_valid && out_data.upper_half, "second span missing")
  // Nothing is offered just after reset.
  `TSS_ASSERT(a_reset_idle, !$past(rst) || !out_valid, "span offered after reset")

endmodule

bind triangle_scanline_span tss_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/triangle_scanline_span_test.sv
// Self-checking testbench for the triangle scanline span generator.
module triangle_scanline_span_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tss_pkg::*;

  localparam int LATENCY = COORD_BITS + 4;

  // Scoreboard: predicts the spans of each accepted query and checks results.
  class span_scoreboard;
    tss_out_t pending_spans[$];
    int errors;
    int queries;
    int spans_seen;
    int doubles;

    function automatic longint edge_at(longint x0, longint y0, longint x1,
                                       longint y1, longint r);
      longint dy;
      dy = y1 - y0;
      if (dy == 0) return x0;
      return x0 + ((x1 - x0) * (r - y0)) / dy;
    endfunction

    function automatic tss_out_t make_span(longint sx, longint ex, bit up,
                                           tss_in_t q);
      tss_out_t s;
      s.span_start_x = sx[COORD_BITS-1:0];
      s.span_end_x   = ex[COORD_BITS-1:0];
      s.upper_half   = up;
      s.red_out      = q.colour_red;
      s.green_out    = q.colour_green;
      s.blue_out     = q.colour_blue;
      s.last_span    = 1'b0;
      return s;
    endfunction

    // Note an accepted query and queue the spans it should give.
    function void note_query(tss_in_t q);
      longint tx, ty, mx, my, bx, by, r, t;
      tss_out_t got[$];
      queries++;
      tx = longint'(q.vertex_a_x); ty = longint'(q.vertex_a_y);
      mx = longint'(q.vertex_b_x); my = longint'(q.vertex_b_y);
      bx = longint'(q.vertex_c_x); by = longint'(q.vertex_c_y);
      r  = longint'(q.row);
      if (ty == my && my == by) return;
      if (tx == mx && mx == bx) return;
      // Sort by y, top largest; ties keep their order.
      if (ty < my) begin t = tx; tx = mx; mx = t; t = ty; ty = my; my = t; end
      if (ty < by) begin t = tx; tx = bx; bx = t; t = ty; ty = by; by = t; end
      if (my < by) begin t = mx; mx = bx; bx = t; t = my; my = by; by = t; end
      if (my - by > 0 && r >= by && r <= my)
        got.push_back(make_span(edge_at(bx, by, mx, my, r),
                                edge_at(bx, by, tx, ty, r), 1'b0, q));
      if (ty - my > 0 && r >= my && r <= ty)
        got.push_back(make_span(edge_at(mx, my, tx, ty, r),
                                edge_at(bx, by, tx, ty, r), 1'b1, q));
      if (got.size() > 0) got[got.size()-1].last_span = 1'b1;
      if (got.size() == 2) doubles++;
      foreach (got[i]) pending_spans.push_back(got[i]);
    endfunction

    // Compare one accepted span with the oldest expectation.
    function void check_span(tss_out_t a);
      tss_out_t e;
      spans_seen++;
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span %h", $time, a);
        errors++;
        return;
      end
      e = pending_spans.pop_front();
      if (a.span_start_x !== e.span_start_x)
        $display("%0t: span_start_x exp %0d got %0d", $time, e.span_start_x, a.span_start_x);
      if (a.span_end_x !== e.span_end_x)
        $display("%0t: span_end_x exp %0d got %0d", $time, e.span_end_x, a.span_end_x);
      if (a.upper_half !== e.upper_half)
        $display("%0t: upper_half exp %0b got %0b", $time, e.upper_half, a.upper_half);
      if (a.red_out !== e.red_out)
        $display("%0t: red_out exp %0d got %0d", $time, e.red_out, a.red_out);
      if (a.green_out !== e.green_out)
        $display("%0t: green_out exp %0d got %0d", $time, e.green_out, a.green_out);
      if (a.blue_out !== e.blue_out)
        $display("%0t: blue_out exp %0d got %0d", $time, e.blue_out, a.blue_out);
      if (a.last_span !== e.last_span)
        $display("%0t: last_span exp %0b got %0b", $time, e.last_span, a.last_span);
      if (a !== e) errors++;
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  tss_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tss_out_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  span_scoreboard board;

  triangle_scanline_span dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls and checking of each accepted transaction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_span(out_data);
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one query and wait for its transaction to be accepted.
  task automatic send_query(tss_in_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_query(q);
  endtask

  function automatic tss_in_t make_query(int ax, int ay, int bx, int by,
                                         int cx, int cy, int r);
    tss_in_t q;
    q.vertex_a_x = ax[COORD_BITS-1:0]; q.vertex_a_y = ay[COORD_BITS-1:0];
    q.vertex_b_x = bx[COORD_BITS-1:0]; q.vertex_b_y = by[COORD_BITS-1:0];
    q.vertex_c_x = cx[COORD_BITS-1:0]; q.vertex_c_y = cy[COORD_BITS-1:0];
    q.row = r[COORD_BITS-1:0];
    q.colour_red = 8'($urandom); q.colour_green = 8'($urandom);
    q.colour_blue = 8'($urandom);
    return q;
  endfunction

  // A mostly sensible triangle with a row inside or near its y range.
  function automatic tss_in_t random_query();
    tss_in_t q;
    int lo, hi, k, span;
    k = $urandom_range(9);
    if (k == 0) begin
      q = make_query(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom), int'($urandom));
      return q;
    end
    span = (k < 4) ? 2047 : (k < 7 ? 64 : 8);
    lo = -2048 + span;
    lo = $urandom_range(0, 4095 - 2 * span) - 2048 + span;
    q = make_query(lo + $urandom_range(0, 2*span) - span, lo + $urandom_range(0, span),
                   lo + $urandom_range(0, 2*span) - span, lo + $urandom_range(0, span),
                   lo + $urandom_range(0, 2*span) - span, lo + $urandom_range(0, span),
                   0);
    if (q.vertex_a_y > q.vertex_b_y) begin hi = q.vertex_a_y; lo = q.vertex_b_y; end
    else begin hi = q.vertex_b_y; lo = q.vertex_a_y; end
    if (q.vertex_c_y > hi) hi = q.vertex_c_y;
    if (q.vertex_c_y < lo) lo = q.vertex_c_y;
    case ($urandom_range(5))
      0: q.row = q.vertex_b_y;
      1: q.row = COORD_BITS'((lo > -2048) ? lo - 1 : hi + 1);
      default: q.row = COORD_BITS'(int'($urandom_range(0, hi - lo)) + lo);
    endcase
    return q;
  endfunction

  initial begin : stimulus
    int n;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 60;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, middle row, flat halves, degenerates, outside rows.
    send_query(make_query(-2048, -2048, 2047, 2047, -2048, 2047, 0));
    send_query(make_query(-2048, -2048, 2047, 2047, -2048, 2047, 2047));
    send_query(make_query(-2048, -2048, 2047, 2047, -2048, 2047, -2048));
    send_query(make_query(2047, 2047, -2048, 0, 2047, -2048, 0));
    send_query(make_query(2047, 2047, -2048, 0, 2047, -2048, -2048));
    send_query(make_query(0, 10, 5, 10, 9, 10, 10));
    send_query(make_query(7, -5, 7, 100, 7, 3, 0));
    send_query(make_query(0, 0, 10, 0, 5, 20, 0));
    send_query(make_query(10, 0, 0, 0, 5, 20, 0));
    send_query(make_query(0, 20, 10, 20, 5, 0, 20));
    send_query(make_query(10, 20, 0, 20, 5, 0, 20));
    send_query(make_query(0, 0, 10, 20, -7, 40, 41));
    send_query(make_query(0, 0, 10, 20, -7, 40, -1));
    send_query(make_query(-3, -1, 1, -7, 5, -4, -4));
    send_query(make_query(-2048, 2047, 2047, -2048, 0, 0, 1));
    send_query(make_query(2047, -2048, -2048, 2047, 2047, 2047, 2047));
    send_query(make_query(-1, -1, -1, -1, 0, 0, -1));
    send_query(make_query(0, 0, 100, 3, -100, 7, 5));

    // Random part in three idling phases.
    for (n = 0; n < 540; n++) begin
      if (n == 180) begin send_idle_pct = 60; recv_idle_pct = 16; end
      if (n == 360) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_query(random_query());
    end
    in_valid <= 1'b0;

    while (board.pending_spans.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Covered %0d row queries giving %0d spans, %0d with both halves.",
             board.queries, board.spans_seen, board.doubles);
    if (board.errors == 0 && board.pending_spans.size() == 0)
      $display("triangle_scanline_span_test: PASS");
    else
      $display("triangle_scanline_span_test: FAIL");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2ms;
    $display("triangle_scanline_span_test: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_front.sv
rtl/tss_queue.sv
rtl/tss_back.sv
rtl/triangle_scanline_span.sv
rtl/tss_checker.sv
verif/triangle_scanline_span_test.sv
